### sv/lmfb_pkg.sv
// Shared command codes, register indexes and controller/datapath interface types.
package lmfb_pkg;

    // Command codes on the cmd port
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_ROW    = 3'd2;
    localparam logic [2:0] CMD_COLUMN = 3'd3;
    localparam logic [2:0] CMD_SPRITE = 3'd4;
    localparam logic [2:0] CMD_WRITE  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_SWAP_BYTES      = 2'd0;
    localparam logic [1:0] CFG_FLIP_VERTICAL   = 2'd1;
    localparam logic [1:0] CFG_FLIP_HORIZONTAL = 2'd2;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;

    // Operation the controller hands to the datapath each cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PIXEL,
        OP_ROW,
        OP_COLUMN,
        OP_SPRITE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last_byte;
    } dp_status_t;

endpackage

### sv/lmfb_ctrl.sv
// Controller: decodes accepted items and sequences the write stream.
module lmfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          cmd,
    input  lmfb_pkg::dp_status_t dp_status,
    output lmfb_pkg::dp_cmd_t   dp_cmd,
    output logic                busy
);
    import lmfb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == ST_STREAM);
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        dp_cmd.op  = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:  dp_cmd.op = OP_CLEAR;
                        CMD_PIXEL:  dp_cmd.op = OP_PIXEL;
                        CMD_ROW:    dp_cmd.op = OP_ROW;
                        CMD_COLUMN: dp_cmd.op = OP_COLUMN;
                        CMD_SPRITE: dp_cmd.op = OP_SPRITE;
                        CMD_WRITE:  state_next = ST_STREAM;
                        default:    dp_cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_STREAM:
            begin
                // one byte per cycle until the datapath reports the final one
                dp_cmd.op = OP_EMIT;
                if (dp_status.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/lmfb_datapath.sv
// Datapath: frame rows, configuration flags, byte counter and output registers.
module lmfb_datapath #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmfb_pkg::dp_cmd_t    dp_cmd,
    output lmfb_pkg::dp_status_t dp_status,
    input  logic [3:0]           col,
    input  logic [2:0]           row,
    input  logic [15:0]          value,
    input  logic [3:0]           col_offset,
    input  logic [2:0]           row_offset,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [0:0]           cfg_data,
    output logic                 byte_valid,
    output logic [7:0]           data_byte,
    output logic                 last
);
    import lmfb_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BYTES = 2 * ROWS;
    localparam int IW    = $clog2(BYTES);

    function automatic logic [WORD_W-1:0] reverse16(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++)
        begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

    logic [WORD_W-1:0] frame_reg  [ROWS];
    logic [WORD_W-1:0] frame_next [ROWS];
    logic              swap_reg;
    logic              flip_v_reg;
    logic              flip_h_reg;
    logic [IW-1:0]     byte_idx_reg;
    logic              byte_valid_reg;
    logic [7:0]        data_byte_reg;
    logic              last_reg;

    // Small elaboration-time tables for the row and column wrap
    logic [RW-1:0] row_mod_tbl [16];
    logic [3:0]    col_mod_tbl [16];

    for (genvar g = 0; g < 16; g++)
    begin : g_mod_tbl
        assign row_mod_tbl[g] = RW'(g % ROWS);
        assign col_mod_tbl[g] = 4'(g % COLS);
    end

    logic [RW-1:0]     row_sel;
    logic [RW-1:0]     sprite_dst;
    logic [3:0]        col_sel;
    logic [WORD_W-1:0] col_mask;
    logic [WORD_W-1:0] sprite_bits;

    assign row_sel     = row_mod_tbl[{1'b0, row}];
    assign sprite_dst  = row_mod_tbl[4'({1'b0, row}) + 4'({1'b0, row_offset})];
    assign col_sel     = col_mod_tbl[col];
    assign col_mask    = WORD_W'(1) << col_sel;
    assign sprite_bits = value << col_offset;

    // Per-row next value; every row decides for itself
    for (genvar g = 0; g < ROWS; g++)
    begin : g_row
        always_comb
        begin
            frame_next[g] = frame_reg[g];
            case (dp_cmd.op)
                OP_CLEAR:
                begin
                    frame_next[g] = '0;
                end
                OP_PIXEL:
                begin
                    if (row_sel == RW'(g))
                    begin
                        frame_next[g] = value[0] ? (frame_reg[g] | col_mask)
                                                 : (frame_reg[g] & ~col_mask);
                    end
                end
                OP_ROW:
                begin
                    if (row_sel == RW'(g))
                    begin
                        frame_next[g] = value;
                    end
                end
                OP_COLUMN:
                begin
                    if (g < 8)
                    begin
                        frame_next[g] = value[g % 8] ? (frame_reg[g] | col_mask)
                                                     : (frame_reg[g] & ~col_mask);
                    end
                end
                OP_SPRITE:
                begin
                    if (sprite_dst == RW'(g))
                    begin
                        frame_next[g] = frame_reg[g] | sprite_bits;
                    end
                end
                default:
                begin
                    frame_next[g] = frame_reg[g];
                end
            endcase
        end
    end

    // Byte selection for the write stream
    logic [RW-1:0]     out_row;
    logic [RW-1:0]     src_row;
    logic [WORD_W-1:0] src_word;
    logic [WORD_W-1:0] send_word;
    logic              take_high;
    logic              at_last;

    assign out_row   = RW'(byte_idx_reg >> 1);
    assign src_row   = flip_v_reg ? (RW'(ROWS - 1) - out_row) : out_row;
    assign src_word  = frame_reg[src_row];
    assign send_word = flip_h_reg ? reverse16(src_word) : src_word;
    assign take_high = byte_idx_reg[0] ^ swap_reg;
    assign at_last   = (byte_idx_reg == IW'(BYTES - 1));

    assign dp_status.last_byte = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                frame_reg[i] <= '0;
            end
            swap_reg       <= 1'b0;
            flip_v_reg     <= 1'b0;
            flip_h_reg     <= 1'b0;
            byte_idx_reg   <= '0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg <= frame_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SWAP_BYTES:      swap_reg   <= cfg_data[0];
                    CFG_FLIP_VERTICAL:   flip_v_reg <= cfg_data[0];
                    CFG_FLIP_HORIZONTAL: flip_h_reg <= cfg_data[0];
                    default:             swap_reg   <= swap_reg;
                endcase
            end
            byte_valid_reg <= (dp_cmd.op == OP_EMIT);
            if (dp_cmd.op == OP_EMIT)
            begin
                byte_idx_reg <= at_last ? '0 : byte_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == OP_EMIT)
        begin
            data_byte_reg <= take_high ? send_word[15:8] : send_word[7:0];
            last_reg      <= at_last;
        end
    end

    assign byte_valid = byte_valid_reg;
    assign data_byte  = data_byte_reg;
    assign last       = last_reg;

endmodule

### sv/led_matrix_frame_buffer.sv
// Top level of the LED matrix frame buffer: controller plus datapath.
//
//  channel   signals                                        handshake
//  --------  ---------------------------------------------  -------------------------
//  command   cmd, col, row, value, col_offset, row_offset   taken when start && !busy
//  config    cfg_we, cfg_index, cfg_data                    written when cfg_we
//  result    data_byte, last                                one cycle when byte_valid
//
//  Buffer updates (clear, pixel, row, column, sprite) finish in the cycle the item
//  is taken; busy stays low, so a new item can follow on the next cycle.
//  A write raises busy while the byte counter walks the rows, one byte per
//  cycle; each byte is registered before it shows on the outputs.
//  Reset clears the frame rows and all configuration flags at once.
//  The receiver cannot stall: every byte is valid for exactly one cycle.
module led_matrix_frame_buffer #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [3:0]  col,
    input  logic [2:0]  row,
    input  logic [15:0] value,
    input  logic [3:0]  col_offset,
    input  logic [2:0]  row_offset,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic        last
);
    import lmfb_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Decode items and advance the write stream
    lmfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy)
    );

    // Hold the frame rows and drive the byte stream
    lmfb_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .col        (col),
        .row        (row),
        .value      (value),
        .col_offset (col_offset),
        .row_offset (row_offset),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .last       (last)
    );

endmodule

### tb/lmfb_tb_pkg.sv
// Frame buffer scoreboard: mirror of the frame and the queue of display bytes due.
`timescale 1ns / 100ps

package lmfb_tb_pkg;

    import lmfb_pkg::*;

    localparam int FRAME_ROWS  = 8;

    // Command codes that the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  col;
        logic [2:0]  row;
        logic [15:0] value;
        logic [3:0]  col_offset;
        logic [2:0]  row_offset;
    } frame_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } disp_byte_t;

    class frame_scoreboard;
        logic [15:0]  frame_mirror [FRAME_ROWS];
        bit           swap_bytes;
        bit           flip_vertical;
        bit           flip_horizontal;
        disp_byte_t   bytes_due [$];
        int unsigned  error_count;

        function new();
            foreach (frame_mirror[r])
                frame_mirror[r] = '0;
            swap_bytes      = 1'b0;
            flip_vertical   = 1'b0;
            flip_horizontal = 1'b0;
            error_count     = 0;
        endfunction

        // Print one line per mismatch and count it
        task report_mismatch(string msg);
            $display("%0t MISMATCH: %s", $realtime, msg);
            error_count++;
        endtask

        function void note_config(logic [1:0] index, logic data);
            case (index)
                CFG_SWAP_BYTES:      swap_bytes      = data;
                CFG_FLIP_VERTICAL:   flip_vertical   = data;
                CFG_FLIP_HORIZONTAL: flip_horizontal = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] mirror_bits(logic [15:0] w);
            logic [15:0] m;
            for (int i = 0; i < 16; i++)
                m[i] = w[15 - i];
            return m;
        endfunction

        // Update the mirror; a write queues the 16 bytes it streams out
        function void note_item(frame_cmd_t c);
            logic [2:0]  dst;
            logic [15:0] w;
            int          src;
            case (c.cmd)
                CMD_CLEAR:
                    foreach (frame_mirror[r])
                        frame_mirror[r] = '0;
                CMD_PIXEL:
                    frame_mirror[c.row][c.col] = c.value[0];
                CMD_ROW:
                    frame_mirror[c.row] = c.value;
                CMD_COLUMN:
                    for (int r = 0; r < FRAME_ROWS; r++)
                        frame_mirror[r][c.col] = c.value[r];
                CMD_SPRITE:
                begin
                    dst = c.row + c.row_offset;
                    w = c.value << c.col_offset;
                    frame_mirror[dst] = frame_mirror[dst] | w;
                end
                CMD_WRITE:
                    for (int r = 0; r < FRAME_ROWS; r++)
                    begin
                        src = flip_vertical ? FRAME_ROWS - 1 - r : r;
                        w = frame_mirror[src];
                        if (flip_horizontal)
                            w = mirror_bits(w);
                        bytes_due.push_back({swap_bytes ? w[15:8] : w[7:0], 1'b0});
                        bytes_due.push_back({swap_bytes ? w[7:0] : w[15:8],
                                             r == FRAME_ROWS - 1});
                    end
                default: ;
            endcase
        endfunction

        task check_byte(logic [7:0] data, logic last);
            disp_byte_t due;
            if (bytes_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last=%b", data, last));
                return;
            end
            due = bytes_due.pop_front();
            if (data !== due.data)
                report_mismatch($sformatf("data_byte %02h, want %02h", data, due.data));
            if (last !== due.last)
                report_mismatch($sformatf("last %b, want %b", last, due.last));
        endtask
    endclass

endpackage

### tb/led_matrix_frame_buffer_tb.sv
// Top-level testbench for the LED matrix frame buffer.
`timescale 1ns / 100ps

module led_matrix_frame_buffer_tb;

    import lmfb_pkg::*;
    import lmfb_tb_pkg::*;

    // Longest run of cycles with no item, byte or register write taken.
    // Sender gaps at the heavy idle rate are geometric and far shorter than
    // the limit, so a quiet run that reaches it means the block has hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to let pass after the last due byte before touching registers
    localparam int SETTLE_CYCLES  = 4;
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 24;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [3:0]  col;
    logic [2:0]  row;
    logic [15:0] value;
    logic [3:0]  col_offset;
    logic [2:0]  row_offset;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [0:0]  cfg_data;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        last;

    frame_scoreboard frame_sb;
    int unsigned     quiet_cycles;

    led_matrix_frame_buffer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .col        (col),
        .row        (row),
        .value      (value),
        .col_offset (col_offset),
        .row_offset (row_offset),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sample everything at the rising edge. Check a byte before noting a new
    // item, so a write taken on the cycle of the previous write's last byte
    // queues its bytes behind that one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid)
                frame_sb.check_byte(data_byte, last);
            if (start && !busy)
                frame_sb.note_item('{cmd, col, row, value, col_offset, row_offset});
            if (cfg_we)
                frame_sb.note_config(cfg_index, cfg_data);
            if (byte_valid || (start && !busy) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Hold start high until the item is taken; the idle roll before it drops
    // start for a random number of cycles. Called and returns at a falling edge.
    task automatic drive_item(frame_cmd_t item, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        cmd        = item.cmd;
        col        = item.col;
        row        = item.row;
        value      = item.value;
        col_offset = item.col_offset;
        row_offset = item.row_offset;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drain the output stream, let the block settle, then load all registers
    task automatic load_config(logic [2:0] setting);
        start = 1'b0;
        while (frame_sb.bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_SWAP_BYTES, setting[0]);
        write_reg(CFG_FLIP_VERTICAL, setting[1]);
        write_reg(CFG_FLIP_HORIZONTAL, setting[2]);
    endtask

    function automatic frame_cmd_t make_item(logic [2:0] code, logic [3:0] c,
                                             logic [2:0] r, logic [15:0] v,
                                             logic [3:0] co, logic [2:0] ro);
        return '{code, c, r, v, co, ro};
    endfunction

    // Random item: mostly buffer edits and writes with full-range fields,
    // an occasional clear and a few ignored codes as noise.
    function automatic frame_cmd_t random_item();
        frame_cmd_t  item;
        int unsigned pick;
        int unsigned vpick;
        pick  = $urandom_range(99);
        vpick = $urandom_range(9);
        if (pick < 3)
            item.cmd = CMD_CLEAR;
        else if (pick < 23)
            item.cmd = CMD_PIXEL;
        else if (pick < 37)
            item.cmd = CMD_ROW;
        else if (pick < 52)
            item.cmd = CMD_COLUMN;
        else if (pick < 74)
            item.cmd = CMD_SPRITE;
        else if (pick < 94)
            item.cmd = CMD_WRITE;
        else
            item.cmd = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
        item.col        = 4'($urandom_range(15));
        item.row        = 3'($urandom_range(7));
        item.col_offset = 4'($urandom_range(15));
        item.row_offset = 3'($urandom_range(7));
        if (vpick == 0)
            item.value = 16'h0000;
        else if (vpick == 1)
            item.value = 16'hFFFF;
        else
            item.value = 16'($urandom_range(16'hFFFF));
        return item;
    endfunction

    initial
    begin
        frame_cmd_t  directed [$];
        int          idle_pct;
        logic [2:0]  setting;

        frame_sb     = new();
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_CLEAR;
        col          = '0;
        row          = '0;
        value        = '0;
        col_offset   = '0;
        row_offset   = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SWAP_BYTES;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset configuration: empty frame, full and
        // corner rows, pixel clear via an even value, column bytes with high
        // bits that must be ignored, sprite overflow and row wrap, ignored codes.
        directed.push_back(make_item(CMD_WRITE,    4'd0,  3'd0, 16'h0000, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_ROW,      4'd0,  3'd0, 16'hFFFF, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_ROW,      4'd0,  3'd7, 16'h8001, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_WRITE,    4'd0,  3'd0, 16'h0000, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_PIXEL,    4'd15, 3'd0, 16'hFFFE, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_PIXEL,    4'd7,  3'd3, 16'h0001, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_PIXEL,    4'd0,  3'd7, 16'hFFFF, 4'd15, 3'd7));
        directed.push_back(make_item(CMD_COLUMN,   4'd15, 3'd0, 16'hFF00, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_COLUMN,   4'd0,  3'd0, 16'h00A5, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_WRITE,    4'd0,  3'd0, 16'h0000, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_SPRITE,   4'd0,  3'd7, 16'hFFFF, 4'd15, 3'd7));
        directed.push_back(make_item(CMD_SPRITE,   4'd0,  3'd0, 16'h1234, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_SPRITE,   4'd0,  3'd4, 16'hF00F, 4'd4,  3'd5));
        directed.push_back(make_item(CMD_SPARE_LO, 4'd9,  3'd2, 16'hFFFF, 4'd3,  3'd1));
        directed.push_back(make_item(CMD_SPARE_HI, 4'd15, 3'd7, 16'hFFFF, 4'd15, 3'd7));
        directed.push_back(make_item(CMD_WRITE,    4'd0,  3'd0, 16'h0000, 4'd0,  3'd0));
        directed.push_back(make_item(CMD_CLEAR,    4'd15, 3'd7, 16'hFFFF, 4'd15, 3'd7));
        directed.push_back(make_item(CMD_WRITE,    4'd0,  3'd0, 16'h0000, 4'd0,  3'd0));
        foreach (directed[i])
            drive_item(directed[i], 6);

        // Random phases: light sender gaps, then heavy gaps, then back to back.
        // Each phase loads a new register setting, covering all eight.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 3)
                idle_pct = 6;
            else if (p < 6)
                idle_pct = 76;
            else
                idle_pct = 0;
            setting = 3'(p * 3);
            load_config(setting);
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_item(random_item(), idle_pct);
        end

        // Drain the last write, then allow a few more cycles for stray bytes
        start = 1'b0;
        while (frame_sb.bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES * 2) @(negedge clk);

        if (frame_sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/lmfb_pkg.sv
sv/lmfb_ctrl.sv
sv/lmfb_datapath.sv
sv/led_matrix_frame_buffer.sv
tb/lmfb_tb_pkg.sv
tb/led_matrix_frame_buffer_tb.sv
